// File: design/command_sentence_parser_macros.svh
// ----------------------------------------------------------------------------
// Command sentence parser assertion macros
// Concurrent assertion shorthands, clocked on clock and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef COMMAND_SENTENCE_PARSER_MACROS_SVH
`define COMMAND_SENTENCE_PARSER_MACROS_SVH

// same-cycle implication
`define CSP_ASSERT_IMPLY(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define CSP_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// File: design/csp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_pkg
// Shared constants, types and decode functions of the command sentence parser.
// ----------------------------------------------------------------------------
package csp_pkg;

   localparam int MAX_FIELDS  = 16;
   localparam int FRAC_DIGITS = 3;

   localparam int FIELD_CNT_W = $clog2(MAX_FIELDS);
   localparam int FRAC_CNT_W  = $clog2(FRAC_DIGITS + 2);
   localparam int SCALE_W     = $clog2(10 ** FRAC_DIGITS + 1);
   localparam int ACC_W       = 32;
   localparam int PROD_W      = ACC_W + SCALE_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [ACC_W-1:0] SAT_MAG = 32'h8000_0000;
   localparam logic [ACC_W-1:0] POS_MAX = 32'h7fff_ffff;

   // ASCII
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_STAR    = 8'h2a;
   localparam logic [7:0] CH_COMMA   = 8'h2c;
   localparam logic [7:0] CH_PLUS    = 8'h2b;
   localparam logic [7:0] CH_MINUS   = 8'h2d;
   localparam logic [7:0] CH_DOT     = 8'h2e;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0d;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;

   localparam logic [4:0] HEX_BAD = 5'h10;

   // letters are held first-received in the low byte
   localparam logic [23:0] TAG_CVW = {"W", "V", "C"};
   localparam logic [23:0] TAG_DPV = {"V", "P", "D"};
   localparam logic [23:0] TAG_SWV = {"V", "W", "S"};
   localparam logic [23:0] TAG_CMD = {"D", "M", "C"};
   localparam logic [23:0] TAG_RUN = {"N", "U", "R"};
   localparam logic [23:0] TAG_CHK = {"K", "H", "C"};
   localparam logic [23:0] TAG_DIE = {"E", "I", "D"};
   localparam logic [23:0] TAG_TIA = {"A", "I", "T"};
   localparam logic [23:0] TAG_CUR = {"R", "U", "C"};

   localparam logic RESULT_FIELD = 1'b0;
   localparam logic RESULT_END   = 1'b1;

   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_UNKNOWN_CMD = 2'd1;
   localparam logic [1:0] ERR_BAD_HEX     = 2'd2;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_BODY,
      PH_HEX_HI,
      PH_HEX_LO
   } phase_type;

   typedef enum logic [3:0] {
      CMD_NONE = 4'd0,
      CMD_CVW  = 4'd1,
      CMD_DPV  = 4'd2,
      CMD_SWV  = 4'd3,
      CMD_RUN  = 4'd4,
      CMD_CHK  = 4'd5,
      CMD_DIE  = 4'd6,
      CMD_TIA  = 4'd7,
      CMD_CUR  = 4'd8
   } command_type;

   typedef enum logic [1:0] {
      FK_NONE,
      FK_FIXED,
      FK_INTEGER
   } field_kind_type;

   // one item handed from the parser to the result stage
   typedef struct packed {
      logic                   kind;
      logic [FIELD_CNT_W-1:0] index;
      logic [ACC_W-1:0]       accum;
      logic [FRAC_CNT_W-1:0]  frac;
      logic                   neg;
      command_type            cmd;
      logic                   checksum_ok;
      logic [1:0]             error_code;
   } csp_event_type;

   function automatic command_type decode_command(input logic [47:0] letters);
      command_type c;
      c = CMD_NONE;
      if (letters[23:0] == TAG_CVW) c = CMD_CVW;
      else if (letters[23:0] == TAG_DPV) c = CMD_DPV;
      else if (letters[23:0] == TAG_SWV) c = CMD_SWV;
      else if (letters[23:0] == TAG_CMD) begin
         if (letters[47:24] == TAG_RUN) c = CMD_RUN;
         else if (letters[47:24] == TAG_CHK) c = CMD_CHK;
         else if (letters[47:24] == TAG_DIE) c = CMD_DIE;
         else if (letters[47:24] == TAG_TIA) c = CMD_TIA;
         else if (letters[47:24] == TAG_CUR) c = CMD_CUR;
      end
      return c;
   endfunction

   function automatic field_kind_type field_kind(input command_type cmd,
                                                 input logic [FIELD_CNT_W-1:0] idx);
      field_kind_type k;
      unique case (cmd)
         CMD_CVW: begin
            if (idx >= FIELD_CNT_W'(6)) k = FK_NONE;
            else if (idx == '0 || idx == FIELD_CNT_W'(5)) k = FK_INTEGER;
            else k = FK_FIXED;
         end
         CMD_DPV: begin
            if (idx >= FIELD_CNT_W'(9)) k = FK_NONE;
            else if (idx == '0 || idx >= FIELD_CNT_W'(5)) k = FK_INTEGER;
            else k = FK_FIXED;
         end
         CMD_SWV: begin
            if (idx >= FIELD_CNT_W'(7)) k = FK_NONE;
            else if (idx == '0 || idx == FIELD_CNT_W'(6)) k = FK_INTEGER;
            else k = FK_FIXED;
         end
         CMD_TIA, CMD_CUR: begin
            k = (idx == FIELD_CNT_W'(1)) ? FK_INTEGER : FK_NONE;
         end
         default: k = FK_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      if (c >= CH_ZERO && c <= CH_NINE) v = {1'b0, c[3:0]};
      else if (c >= CH_UPPER_A && c <= CH_UPPER_F) v = {1'b0, 4'(c - CH_UPPER_A + 8'd10)};
      else if (c >= CH_LOWER_A && c <= CH_LOWER_F) v = {1'b0, 4'(c - CH_LOWER_A + 8'd10)};
      else v = HEX_BAD;
      return v;
   endfunction

   // 10 ** (FRAC_DIGITS - frac): pads the missing fraction digits
   function automatic logic [SCALE_W-1:0] scale_for(input logic [FRAC_CNT_W-1:0] frac);
      logic [SCALE_W-1:0] s;
      s = SCALE_W'(1);
      for (int i = 0; i < FRAC_DIGITS; i++) begin
         if (FRAC_CNT_W'(i) >= frac) s = SCALE_W'(s * 10);
      end
      return s;
   endfunction

endpackage

// File: design/csp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_req_if / csp_rsp_if
// Valid/ready channels carrying sentence bytes in and parse results out.
// ----------------------------------------------------------------------------
interface csp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface csp_rsp_if;
   logic               valid;
   logic               ready;
   logic               result_kind;
   logic [3:0]         field_index;
   logic signed [31:0] field_value;
   logic [3:0]         command_code;
   logic               checksum_ok;
   logic [1:0]         error_code;

   modport source (output valid, output result_kind, output field_index,
                   output field_value, output command_code, output checksum_ok,
                   output error_code, input ready);
   modport sink   (input valid, input result_kind, input field_index,
                   input field_value, input command_code, input checksum_ok,
                   input error_code, output ready);
endinterface

// File: design/csp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_front
// Byte-wise sentence parser: framing, checksum, command letters, number
// accumulation. Pushes one item per field result or end of sentence.
// ----------------------------------------------------------------------------
module csp_front (
   input  logic                   clock,
   input  logic                   reset,
   csp_req_if.sink                req_chan,
   input  logic                   q_space,
   output logic                   ev_push,
   output csp_pkg::csp_event_type ev
);

   csp_pkg::phase_type                  phase_ff, phase_in;
   logic [7:0]                          xor_ff, xor_in;
   logic [7:0]                          pos_ff, pos_in;
   logic [47:0]                         letters_ff, letters_in;
   logic [csp_pkg::FIELD_CNT_W-1:0]     field_cnt_ff, field_cnt_in;
   logic [csp_pkg::ACC_W-1:0]           accum_ff, accum_in;
   logic [csp_pkg::FRAC_CNT_W-1:0]      frac_cnt_ff, frac_cnt_in;
   logic                                neg_ff, neg_in;
   logic                                frac_ff, frac_in;
   logic                                stop_ff, stop_in;
   logic                                token_ff, token_in;
   logic                                past_ff, past_in;
   logic                                begun_ff, begun_in;
   logic [4:0]                          high_nib_ff, high_nib_in;

   logic [7:0]                          b;
   logic                                accept;
   logic [7:0]                          pos_step;
   logic [47:0]                         letters_step;
   csp_pkg::command_type                cmd_now;
   csp_pkg::field_kind_type             kind_now;
   logic                                is_digit;
   logic                                is_space;
   logic [csp_pkg::ACC_W+3:0]           mac_sum;
   logic [csp_pkg::ACC_W-1:0]           mac_val;
   logic [4:0]                          lo_nib;
   logic                                hex_bad;

   assign req_chan.ready = q_space;
   assign accept = req_chan.valid && q_space;
   assign b = req_chan.rx_byte;

   assign pos_step = (pos_ff != 8'hff) ? pos_ff + 8'd1 : pos_ff;

   always_comb begin
      letters_step = letters_ff;
      case (pos_step)
         8'd1:    letters_step[7:0]   = b;
         8'd2:    letters_step[15:8]  = b;
         8'd3:    letters_step[23:16] = b;
         8'd5:    letters_step[31:24] = b;
         8'd6:    letters_step[39:32] = b;
         8'd7:    letters_step[47:40] = b;
         default: letters_step = letters_ff;
      endcase
   end

   assign cmd_now  = csp_pkg::decode_command(letters_step);
   assign kind_now = csp_pkg::field_kind(cmd_now, field_cnt_ff);

   assign is_digit = (b >= csp_pkg::CH_ZERO) && (b <= csp_pkg::CH_NINE);
   assign is_space = (b == csp_pkg::CH_SPACE) ||
                     ((b >= csp_pkg::CH_TAB) && (b <= csp_pkg::CH_CR));

   // accum * 10 + digit, clamped at the magnitude of the most negative value
   assign mac_sum = ((csp_pkg::ACC_W+4)'(accum_ff) << 3) + ((csp_pkg::ACC_W+4)'(accum_ff) << 1)
                    + (csp_pkg::ACC_W+4)'(b[3:0]);
   assign mac_val = (mac_sum > (csp_pkg::ACC_W+4)'(csp_pkg::SAT_MAG)) ? csp_pkg::SAT_MAG
                                                                     : mac_sum[csp_pkg::ACC_W-1:0];

   assign lo_nib  = csp_pkg::hex_value(b);
   assign hex_bad = high_nib_ff[4] || lo_nib[4];

   always_comb begin
      phase_in     = phase_ff;
      xor_in       = xor_ff;
      pos_in       = pos_ff;
      letters_in   = letters_ff;
      field_cnt_in = field_cnt_ff;
      accum_in     = accum_ff;
      frac_cnt_in  = frac_cnt_ff;
      neg_in       = neg_ff;
      frac_in      = frac_ff;
      stop_in      = stop_ff;
      token_in     = token_ff;
      past_in      = past_ff;
      begun_in     = begun_ff;
      high_nib_in  = high_nib_ff;
      ev_push      = 1'b0;
      ev           = '0;
      ev.kind      = csp_pkg::RESULT_FIELD;
      ev.index     = field_cnt_ff;
      ev.accum     = accum_ff;
      ev.frac      = frac_cnt_ff;
      ev.neg       = neg_ff;
      ev.cmd       = cmd_now;

      if (accept) begin
         if (b == csp_pkg::CH_DOLLAR) begin
            phase_in     = csp_pkg::PH_BODY;
            xor_in       = '0;
            pos_in       = '0;
            letters_in   = '0;
            field_cnt_in = '0;
            accum_in     = '0;
            frac_cnt_in  = '0;
            neg_in       = 1'b0;
            frac_in      = 1'b0;
            stop_in      = 1'b0;
            token_in     = 1'b0;
            past_in      = 1'b0;
            begun_in     = 1'b0;
            high_nib_in  = '0;
         end else if (phase_ff != csp_pkg::PH_IDLE) begin
            pos_in     = pos_step;
            letters_in = letters_step;
            unique case (phase_ff)
               csp_pkg::PH_BODY: begin
                  if (b == csp_pkg::CH_STAR) begin
                     phase_in = csp_pkg::PH_HEX_HI;
                     // the open field is closed by the star, even when empty
                     ev_push  = past_ff && (kind_now != csp_pkg::FK_NONE);
                  end else begin
                     xor_in = xor_ff ^ b;
                     if (b == csp_pkg::CH_COMMA) begin
                        if (!past_ff || token_ff) begin
                           if (past_ff) begin
                              ev_push = (kind_now != csp_pkg::FK_NONE);
                              if (field_cnt_ff != csp_pkg::FIELD_CNT_W'(csp_pkg::MAX_FIELDS - 1))
                                 field_cnt_in = field_cnt_ff + 1'b1;
                           end
                           past_in     = 1'b1;
                           token_in    = 1'b0;
                           neg_in      = 1'b0;
                           frac_in     = 1'b0;
                           stop_in     = 1'b0;
                           accum_in    = '0;
                           frac_cnt_in = '0;
                           begun_in    = 1'b0;
                        end
                        // empty field: nothing moves
                     end else begin
                        token_in = 1'b1;
                        if (past_ff && !stop_ff) begin
                           if (!begun_ff && is_space) begin
                              begun_in = 1'b0;
                           end else if (!begun_ff && b == csp_pkg::CH_MINUS) begin
                              begun_in = 1'b1;
                              neg_in   = 1'b1;
                           end else if (!begun_ff && b == csp_pkg::CH_PLUS) begin
                              begun_in = 1'b1;
                           end else begin
                              begun_in = 1'b1;
                              if (is_digit) begin
                                 if (!frac_ff) begin
                                    accum_in = mac_val;
                                 end else if (frac_cnt_ff <
                                              csp_pkg::FRAC_CNT_W'(csp_pkg::FRAC_DIGITS)) begin
                                    accum_in    = mac_val;
                                    frac_cnt_in = frac_cnt_ff + 1'b1;
                                 end
                              end else if (b == csp_pkg::CH_DOT && !frac_ff &&
                                           kind_now != csp_pkg::FK_INTEGER) begin
                                 frac_in = 1'b1;
                              end else begin
                                 stop_in = 1'b1;
                              end
                           end
                        end
                     end
                  end
               end
               csp_pkg::PH_HEX_HI: begin
                  high_nib_in = lo_nib;
                  phase_in    = csp_pkg::PH_HEX_LO;
               end
               csp_pkg::PH_HEX_LO: begin
                  phase_in       = csp_pkg::PH_IDLE;
                  ev_push        = 1'b1;
                  ev.kind        = csp_pkg::RESULT_END;
                  ev.index       = '0;
                  ev.accum       = '0;
                  ev.frac        = '0;
                  ev.neg         = 1'b0;
                  ev.checksum_ok = !hex_bad && ({high_nib_ff[3:0], lo_nib[3:0]} == xor_ff);
                  if (cmd_now == csp_pkg::CMD_NONE) ev.error_code = csp_pkg::ERR_UNKNOWN_CMD;
                  else if (hex_bad) ev.error_code = csp_pkg::ERR_BAD_HEX;
                  else ev.error_code = csp_pkg::ERR_NONE;
               end
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= csp_pkg::PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // everything else is cleared by the opening dollar before it is read
   always_ff @(posedge clock) begin
      xor_ff       <= xor_in;
      pos_ff       <= pos_in;
      letters_ff   <= letters_in;
      field_cnt_ff <= field_cnt_in;
      accum_ff     <= accum_in;
      frac_cnt_ff  <= frac_cnt_in;
      neg_ff       <= neg_in;
      frac_ff      <= frac_in;
      stop_ff      <= stop_in;
      token_ff     <= token_in;
      past_ff      <= past_in;
      begun_ff     <= begun_in;
      high_nib_ff  <= high_nib_in;
   end

endmodule

// File: design/csp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_queue
// Small FIFO between the parser and the result stage.
// ----------------------------------------------------------------------------
module csp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  csp_pkg::csp_event_type push_ev,
   output logic                   space,
   output logic                   q_valid,
   output csp_pkg::csp_event_type q_ev,
   input  logic                   q_ready
);

   csp_pkg::csp_event_type              entries_ff [csp_pkg::QUEUE_DEPTH];
   logic [csp_pkg::QUEUE_PTR_W-1:0]     head_ff, head_in;
   logic [csp_pkg::QUEUE_PTR_W-1:0]     tail_ff, tail_in;
   logic [csp_pkg::QUEUE_PTR_W:0]       count_ff, count_in;
   logic                                pop;

   assign space   = (count_ff != (csp_pkg::QUEUE_PTR_W+1)'(csp_pkg::QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_ev    = entries_ff[head_ff];
   assign pop     = q_valid && q_ready;

   always_comb begin
      head_in  = pop  ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[tail_ff] <= push_ev;
      end
   end

endmodule

// File: design/csp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_back
// Result stage: scales the accumulated magnitude to milli-units, saturates,
// applies the sign and holds the result in the output register.
// ----------------------------------------------------------------------------
module csp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  csp_pkg::csp_event_type q_ev,
   output logic                   q_ready,
   csp_rsp_if.source              rsp_chan
);

   logic                                a_valid_ff, a_valid_in;
   csp_pkg::csp_event_type              a_ev_ff;
   logic [csp_pkg::PROD_W-1:0]          a_prod_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_kind_ff;
   logic [3:0]                          rsp_index_ff;
   logic [csp_pkg::ACC_W-1:0]           rsp_value_ff;
   logic [3:0]                          rsp_cmd_ff;
   logic                                rsp_ok_ff;
   logic [1:0]                          rsp_err_ff;

   logic                                out_en;
   logic                                a_en;
   logic [csp_pkg::ACC_W-1:0]           mag;
   logic [csp_pkg::ACC_W-1:0]           value;

   assign out_en  = !rsp_valid_ff || rsp_chan.ready;
   assign a_en    = !a_valid_ff || out_en;
   assign q_ready = a_en;

   assign a_valid_in   = a_en ? q_valid : a_valid_ff;
   assign rsp_valid_in = out_en ? a_valid_ff : rsp_valid_ff;

   // repeated x10 with clamping collapses to one multiply and one clamp
   assign mag = (a_prod_ff > csp_pkg::PROD_W'(csp_pkg::SAT_MAG)) ? csp_pkg::SAT_MAG
                                                              : a_prod_ff[csp_pkg::ACC_W-1:0];

   always_comb begin
      if (a_ev_ff.neg) value = '0 - mag;
      else if (mag[csp_pkg::ACC_W-1]) value = csp_pkg::POS_MAX;
      else value = mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_ev_ff   <= q_ev;
         a_prod_ff <= csp_pkg::PROD_W'(q_ev.accum) *
                      csp_pkg::PROD_W'(csp_pkg::scale_for(q_ev.frac));
      end
      if (out_en) begin
         rsp_kind_ff  <= a_ev_ff.kind;
         rsp_index_ff <= a_ev_ff.index[3:0];
         rsp_value_ff <= value;
         rsp_cmd_ff   <= 4'(a_ev_ff.cmd);
         rsp_ok_ff    <= a_ev_ff.checksum_ok;
         rsp_err_ff   <= a_ev_ff.error_code;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_kind  = rsp_kind_ff;
   assign rsp_chan.field_index  = rsp_index_ff;
   assign rsp_chan.field_value  = $signed(rsp_value_ff);
   assign rsp_chan.command_code = rsp_cmd_ff;
   assign rsp_chan.checksum_ok  = rsp_ok_ff;
   assign rsp_chan.error_code   = rsp_err_ff;

endmodule

// File: design/command_sentence_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_sentence_parser
// Streaming parser for '$'-framed, comma-separated command sentences with an
// XOR checksum, giving fixed-point field values and an end-of-sentence status.
// ----------------------------------------------------------------------------
// Takes one byte per clock, every clock, for as long as results are taken.
// The parser front end settles each byte in the cycle it is accepted and
// pushes at most one item into a four-entry queue; the result stage pops one
// item per cycle while its output is taken, scales it to milli-units in a
// registered multiply, then saturates and signs it into the output register,
// from which it shows on rsp_chan. req_chan.ready falls only when the queue
// is full, which takes a stalled result side.
`include "command_sentence_parser_macros.svh"

module command_sentence_parser (
   input  logic      clock,
   input  logic      reset,
   csp_req_if.sink   req_chan,
   csp_rsp_if.source rsp_chan
);

   logic                   q_space;
   logic                   ev_push;
   csp_pkg::csp_event_type ev;
   logic                   q_valid;
   csp_pkg::csp_event_type q_ev;
   logic                   q_ready;

   logic                   rsp_is_end;
   logic                   rsp_is_field;
   logic                   rsp_bad_hex;
   logic                   end_fields_zero;
   logic                   field_cmd_known;

   csp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_space  (q_space),
      .ev_push  (ev_push),
      .ev       (ev)
   );

   csp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (ev_push),
      .push_ev (ev),
      .space   (q_space),
      .q_valid (q_valid),
      .q_ev    (q_ev),
      .q_ready (q_ready)
   );

   csp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_ev     (q_ev),
      .q_ready  (q_ready),
      .rsp_chan (rsp_chan)
   );

   assign rsp_is_end      = rsp_chan.valid && (rsp_chan.result_kind == csp_pkg::RESULT_END);
   assign rsp_is_field    = rsp_chan.valid && (rsp_chan.result_kind == csp_pkg::RESULT_FIELD);
   assign rsp_bad_hex     = rsp_chan.valid && (rsp_chan.error_code == csp_pkg::ERR_BAD_HEX);
   assign end_fields_zero = (rsp_chan.field_index == 4'd0) && (rsp_chan.field_value == 32'sd0);
   assign field_cmd_known = (rsp_chan.command_code == csp_pkg::CMD_CVW) ||
                            (rsp_chan.command_code == csp_pkg::CMD_DPV) ||
                            (rsp_chan.command_code == csp_pkg::CMD_SWV) ||
                            (rsp_chan.command_code == csp_pkg::CMD_TIA) ||
                            (rsp_chan.command_code == csp_pkg::CMD_CUR);

   `CSP_ASSERT_IMPLY(a_no_overflow, ev_push, q_space, "item pushed into a full queue")
   `CSP_ASSERT_NEXT(a_push_held, ev_push && !(q_valid && q_ready), q_valid, "pushed item lost")
   `CSP_ASSERT_IMPLY(a_end_clean, rsp_is_end, end_fields_zero, "end item with field data")
   `CSP_ASSERT_IMPLY(a_field_cmd, rsp_is_field, field_cmd_known, "field item, fieldless command")
   `CSP_ASSERT_IMPLY(a_bad_hex, rsp_bad_hex, !rsp_chan.checksum_ok, "bad hex with checksum good")

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for command_sentence_parser. Sentence bytes are queued
// up front, directed sentences first and random ones after, and driven with
// random gaps. Every accepted byte runs through a bit-accurate predictor.
// Each returned item is checked against the oldest predicted item.
// ----------------------------------------------------------------------------
module testbench;

   localparam int TARGET_BYTES = 1850;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_REPORTS  = 10;

   // how a sentence is closed
   localparam int CK_GOOD_UPPER = 0;
   localparam int CK_GOOD_LOWER = 1;
   localparam int CK_WRONG      = 2;
   localparam int CK_BAD_HIGH   = 3;
   localparam int CK_BAD_LOW    = 4;
   localparam int CK_TRUNCATED  = 5;
   localparam int CK_STAR_ONLY  = 6;

   typedef struct packed {
      logic        kind;
      logic [3:0]  index;
      logic [31:0] value;
      logic [3:0]  cmd;
      logic        ok;
      logic [1:0]  err;
   } parse_result_type;

   logic clock;
   logic reset;

   csp_req_if req_chan();
   csp_rsp_if rsp_chan();

   command_sentence_parser DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   logic [7:0]       sentence_stream[$];
   logic [7:0]       body_bytes[$];
   parse_result_type expected_results[$];

   int  error_count    = 0;
   int  bytes_accepted = 0;
   int  field_results  = 0;
   int  end_results    = 0;
   int  sentences_made = 0;
   int  idle_cycles    = 0;
   int  send_wait      = 0;
   int  take_wait      = 0;
   bit  send_calm      = 0;
   bit  take_calm      = 0;
   bit  hold_results   = 0;
   bit  req_taken      = 0;
   bit  rsp_taken      = 0;

   // ------------------------------------------------------------------------
   // sentence predictor
   // ------------------------------------------------------------------------
   csp_pkg::phase_type sp_phase;
   logic [7:0]         sp_xor;
   logic [7:0]         sp_pos;
   logic [47:0]        sp_letters;
   logic [3:0]         sp_field;
   logic [31:0]        sp_accum;
   bit                 sp_neg, sp_frac, sp_stop, sp_token, sp_past, sp_begun;
   logic [4:0]         sp_high;
   int                 sp_frac_n;

   task automatic clear_sentence();
      sp_phase   = csp_pkg::PH_IDLE;
      sp_xor     = '0;
      sp_pos     = '0;
      sp_letters = '0;
      sp_field   = '0;
      sp_accum   = '0;
      sp_neg     = 0;
      sp_frac    = 0;
      sp_stop    = 0;
      sp_token   = 0;
      sp_past    = 0;
      sp_begun   = 0;
      sp_high    = '0;
      sp_frac_n  = 0;
   endtask

   function automatic logic [23:0] pack3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      return {c, b, a};
   endfunction

   function automatic csp_pkg::command_type sentence_command();
      logic [23:0] head, tail;
      head = sp_letters[23:0];
      tail = sp_letters[47:24];
      if (head == pack3("C", "V", "W")) return csp_pkg::CMD_CVW;
      if (head == pack3("D", "P", "V")) return csp_pkg::CMD_DPV;
      if (head == pack3("S", "W", "V")) return csp_pkg::CMD_SWV;
      if (head == pack3("C", "M", "D")) begin
         if (tail == pack3("R", "U", "N")) return csp_pkg::CMD_RUN;
         if (tail == pack3("C", "H", "K")) return csp_pkg::CMD_CHK;
         if (tail == pack3("D", "I", "E")) return csp_pkg::CMD_DIE;
         if (tail == pack3("T", "I", "A")) return csp_pkg::CMD_TIA;
         if (tail == pack3("C", "U", "R")) return csp_pkg::CMD_CUR;
      end
      return csp_pkg::CMD_NONE;
   endfunction

   function automatic csp_pkg::field_kind_type field_use(csp_pkg::command_type c,
                                                         logic [3:0] idx);
      csp_pkg::field_kind_type k;
      k = csp_pkg::FK_NONE;
      case (c)
         csp_pkg::CMD_CVW: begin
            if (idx == 0 || idx == 5) k = csp_pkg::FK_INTEGER;
            else if (idx < 6) k = csp_pkg::FK_FIXED;
         end
         csp_pkg::CMD_DPV: begin
            if (idx == 0 || (idx >= 5 && idx < 9)) k = csp_pkg::FK_INTEGER;
            else if (idx < 5) k = csp_pkg::FK_FIXED;
         end
         csp_pkg::CMD_SWV: begin
            if (idx == 0 || idx == 6) k = csp_pkg::FK_INTEGER;
            else if (idx < 7) k = csp_pkg::FK_FIXED;
         end
         csp_pkg::CMD_TIA, csp_pkg::CMD_CUR: begin
            if (idx == 1) k = csp_pkg::FK_INTEGER;
         end
         default: k = csp_pkg::FK_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] times_ten_plus(logic [31:0] m, logic [7:0] d);
      logic [63:0] t;
      t = 64'(m) * 64'd10 + 64'(d);
      return t > 64'h8000_0000 ? csp_pkg::SAT_MAG : t[31:0];
   endfunction

   function automatic logic [4:0] hex_digit_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return 5'(c - "0");
      if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
      if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
      return csp_pkg::HEX_BAD;
   endfunction

   function automatic logic [31:0] milli_value();
      logic [31:0] mag;
      mag = sp_accum;
      for (int k = sp_frac_n; k < csp_pkg::FRAC_DIGITS; k++) mag = times_ten_plus(mag, 8'd0);
      if (sp_neg) return 32'd0 - mag;
      return mag >= csp_pkg::SAT_MAG ? csp_pkg::POS_MAX : mag;
   endfunction

   task automatic expect_result(logic kind, logic [3:0] index, logic [31:0] value,
                                csp_pkg::command_type cmd, logic ok, logic [1:0] err);
      parse_result_type r;
      r.kind  = kind;
      r.index = index;
      r.value = value;
      r.cmd   = cmd;
      r.ok    = ok;
      r.err   = err;
      expected_results.push_back(r);
   endtask

   task automatic close_field();
      csp_pkg::command_type c;
      c = sentence_command();
      if (field_use(c, sp_field) != csp_pkg::FK_NONE)
         expect_result(csp_pkg::RESULT_FIELD, sp_field, milli_value(), c, 1'b0,
                       csp_pkg::ERR_NONE);
   endtask

   task automatic clear_number();
      sp_accum  = '0;
      sp_neg    = 0;
      sp_frac   = 0;
      sp_stop   = 0;
      sp_token  = 0;
      sp_frac_n = 0;
      sp_begun  = 0;
   endtask

   task automatic feed_number(logic [7:0] b);
      if (sp_stop) return;
      if (!sp_begun) begin
         if (b == csp_pkg::CH_SPACE || (b >= 8'd9 && b <= 8'd13)) return;
         sp_begun = 1;
         if (b == csp_pkg::CH_MINUS) begin
            sp_neg = 1;
            return;
         end
         if (b == csp_pkg::CH_PLUS) return;
      end
      if (b >= csp_pkg::CH_ZERO && b <= csp_pkg::CH_NINE) begin
         if (!sp_frac) begin
            sp_accum = times_ten_plus(sp_accum, b - csp_pkg::CH_ZERO);
         end else if (sp_frac_n < csp_pkg::FRAC_DIGITS) begin
            sp_accum = times_ten_plus(sp_accum, b - csp_pkg::CH_ZERO);
            sp_frac_n++;
         end
      end else if (b == csp_pkg::CH_DOT && !sp_frac &&
                   field_use(sentence_command(), sp_field) != csp_pkg::FK_INTEGER) begin
         sp_frac = 1;
      end else begin
         sp_stop = 1;
      end
   endtask

   task automatic parse_byte(logic [7:0] b);
      logic [4:0]           low;
      csp_pkg::command_type c;
      bit                   bad;
      bit                   ok;
      if (b == csp_pkg::CH_DOLLAR) begin
         clear_sentence();
         sp_phase = csp_pkg::PH_BODY;
         return;
      end
      if (sp_phase == csp_pkg::PH_IDLE) return;
      if (sp_pos < 8'd255) sp_pos++;
      // command letters sit at positions 1-3 and 5-7
      if (sp_pos >= 1 && sp_pos <= 3)
         sp_letters = sp_letters | (48'(b) << (8 * (sp_pos - 1)));
      else if (sp_pos >= 5 && sp_pos <= 7)
         sp_letters = sp_letters | (48'(b) << (8 * (sp_pos - 2)));
      case (sp_phase)
         csp_pkg::PH_BODY: begin
            if (b == csp_pkg::CH_STAR) begin
               sp_phase = csp_pkg::PH_HEX_HI;
               if (sp_past) close_field();
               return;
            end
            sp_xor = sp_xor ^ b;
            if (b == csp_pkg::CH_COMMA) begin
               if (!sp_past) begin
                  sp_past = 1;
                  clear_number();
               end else if (sp_token) begin
                  close_field();
                  if (sp_field < 4'(csp_pkg::MAX_FIELDS - 1)) sp_field++;
                  clear_number();
               end
               return;
            end
            sp_token = 1;
            if (sp_past) feed_number(b);
         end
         csp_pkg::PH_HEX_HI: begin
            sp_high  = hex_digit_value(b);
            sp_phase = csp_pkg::PH_HEX_LO;
         end
         default: begin
            low = hex_digit_value(b);
            c   = sentence_command();
            bad = (sp_high == csp_pkg::HEX_BAD) || (low == csp_pkg::HEX_BAD);
            ok  = !bad && ({sp_high[3:0], low[3:0]} == sp_xor);
            expect_result(csp_pkg::RESULT_END, 4'd0, 32'd0, c, ok,
                          c == csp_pkg::CMD_NONE ? csp_pkg::ERR_UNKNOWN_CMD :
                          bad ? csp_pkg::ERR_BAD_HEX : csp_pkg::ERR_NONE);
            sp_phase = csp_pkg::PH_IDLE;
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // sentence builder
   // ------------------------------------------------------------------------
   function automatic logic [7:0] hex_char(logic [3:0] v, bit lower);
      if (v < 10) return "0" + v;
      return (lower ? "a" : "A") + v - 8'd10;
   endfunction

   function automatic logic [7:0] random_body_byte();
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255));
      while (v == csp_pkg::CH_DOLLAR || v == csp_pkg::CH_STAR);
      return v;
   endfunction

   function automatic logic [7:0] non_hex_byte();
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255));
      while (hex_digit_value(v) != csp_pkg::HEX_BAD || v == csp_pkg::CH_DOLLAR);
      return v;
   endfunction

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) body_bytes.push_back(s[i]);
   endtask

   task automatic close_sentence(int how);
      logic [7:0] sum;
      sum = '0;
      foreach (body_bytes[i]) sum = sum ^ body_bytes[i];
      sentence_stream.push_back(csp_pkg::CH_DOLLAR);
      foreach (body_bytes[i]) sentence_stream.push_back(body_bytes[i]);
      body_bytes.delete();
      sentences_made++;
      if (how == CK_TRUNCATED) return;
      sentence_stream.push_back(csp_pkg::CH_STAR);
      case (how)
         CK_GOOD_UPPER, CK_GOOD_LOWER: begin
            sentence_stream.push_back(hex_char(sum[7:4], how == CK_GOOD_LOWER));
            sentence_stream.push_back(hex_char(sum[3:0], how == CK_GOOD_LOWER));
         end
         CK_WRONG: begin
            sum = sum ^ (8'd1 << $urandom_range(0, 7));
            sentence_stream.push_back(hex_char(sum[7:4], 0));
            sentence_stream.push_back(hex_char(sum[3:0], 0));
         end
         CK_BAD_HIGH: begin
            sentence_stream.push_back(non_hex_byte());
            sentence_stream.push_back(hex_char(sum[3:0], 0));
         end
         CK_BAD_LOW: begin
            sentence_stream.push_back(hex_char(sum[7:4], 0));
            sentence_stream.push_back(non_hex_byte());
         end
         default: ;
      endcase
   endtask

   task automatic add_number();
      int n_ws, n_int, n_frac, r;
      n_ws = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 2) : 0;
      for (int i = 0; i < n_ws; i++) begin
         r = $urandom_range(8, 13);
         body_bytes.push_back(r == 8 ? csp_pkg::CH_SPACE : 8'(r));
      end
      r = $urandom_range(0, 5);
      if (r == 0 || r == 2) body_bytes.push_back(csp_pkg::CH_MINUS);
      else if (r == 1) body_bytes.push_back(csp_pkg::CH_PLUS);
      r = $urandom_range(0, 19);
      n_int = (r == 0) ? 0 : (r == 1) ? $urandom_range(8, 12) : $urandom_range(1, 4);
      for (int i = 0; i < n_int; i++) body_bytes.push_back("0" + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 2) == 0) begin
         body_bytes.push_back(csp_pkg::CH_DOT);
         n_frac = $urandom_range(0, 5);
         for (int i = 0; i < n_frac; i++) body_bytes.push_back("0" + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 9) == 0) begin
         r = $urandom_range(0, 3);
         body_bytes.push_back(r == 0 ? "x" : r == 1 ? csp_pkg::CH_DOT :
                              r == 2 ? csp_pkg::CH_MINUS : csp_pkg::CH_SPACE);
      end
   endtask

   task automatic add_random_sentence();
      string names[8];
      int    pick, n_fields, r;
      names = '{"CVW", "DPV", "SWV", "RUN", "CHK", "DIE", "TIA", "CUR"};
      pick = $urandom_range(0, 8);
      if (pick < 3) begin
         add_text(names[pick]);
      end else if (pick < 8) begin
         add_text("CMD");
         body_bytes.push_back($urandom_range(0, 7) == 0 ? random_body_byte()
                                                        : csp_pkg::CH_COMMA);
         add_text(names[pick]);
      end else begin
         if ($urandom_range(0, 1) == 0) add_text("CMD,");
         for (int i = 0; i < 3; i++) body_bytes.push_back("A" + 8'($urandom_range(0, 25)));
      end
      r = $urandom_range(0, 24);
      n_fields = (r == 0) ? $urandom_range(16, 20) : $urandom_range(0, 10);
      for (int i = 0; i < n_fields; i++) begin
         body_bytes.push_back(csp_pkg::CH_COMMA);
         if ($urandom_range(0, 9) != 0) add_number();
         if ($urandom_range(0, 24) == 0) body_bytes.push_back(random_body_byte());
      end
      // rare overlong sentence can run the byte position into saturation
      if ($urandom_range(0, 39) == 0) begin
         body_bytes.push_back(csp_pkg::CH_COMMA);
         for (int i = 0; i < 240; i++) body_bytes.push_back("9");
      end
      r = $urandom_range(0, 19);
      case (r)
         0: close_sentence(CK_WRONG);
         1: close_sentence(CK_BAD_HIGH);
         2: close_sentence(CK_BAD_LOW);
         3: close_sentence(CK_TRUNCATED);
         4: close_sentence(CK_STAR_ONLY);
         5, 6: close_sentence(CK_GOOD_LOWER);
         default: close_sentence(CK_GOOD_UPPER);
      endcase
      if ($urandom_range(0, 7) == 0) begin
         r = $urandom_range(1, 4);
         for (int i = 0; i < r; i++) sentence_stream.push_back(random_body_byte());
      end
   endtask

   task automatic add_sentence(string body, int how);
      add_text(body);
      close_sentence(how);
   endtask

   // ------------------------------------------------------------------------
   // byte driver
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid   <= 1'b0;
         req_chan.rx_byte <= '0;
      end else begin
         if (req_chan.valid && req_taken) begin
            if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
            send_wait = (send_calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
         end
         if (req_chan.valid && !req_taken) begin
            // item still on offer
         end else if (send_wait > 0 && !hold_results) begin
            send_wait--;
            req_chan.valid <= 1'b0;
         end else if (sentence_stream.size() > 0) begin
            req_chan.rx_byte <= sentence_stream.pop_front();
            req_chan.valid   <= 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // result receiver
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 63) == 0) take_calm = !take_calm;
            take_wait = (take_calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
         end
         if (hold_results) begin
            rsp_chan.ready <= 1'b0;
         end else if (take_wait > 0) begin
            take_wait--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor and checker
   // ------------------------------------------------------------------------
   function automatic string describe(parse_result_type r);
      return $sformatf("kind=%0d index=%0d value=%0d command=%0d csum_ok=%0d error=%0d",
                       r.kind, r.index, $signed(r.value), r.cmd, r.ok, r.err);
   endfunction

   task automatic check_result();
      parse_result_type got, want;
      got.kind  = rsp_chan.result_kind;
      got.index = rsp_chan.field_index;
      got.value = rsp_chan.field_value;
      got.cmd   = rsp_chan.command_code;
      got.ok    = rsp_chan.checksum_ok;
      got.err   = rsp_chan.error_code;
      if (got.kind == csp_pkg::RESULT_END) end_results++;
      else field_results++;
      if (expected_results.size() == 0) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("ERROR: unexpected item: %s", describe(got));
         return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind || got.index !== want.index || got.value !== want.value ||
          got.cmd !== want.cmd || got.ok !== want.ok || got.err !== want.err) begin
         error_count++;
         if (error_count <= MAX_REPORTS) begin
            $display("ERROR: item mismatch at %0t", $time);
            $display("   expected %s", describe(want));
            $display("   actual   %s", describe(got));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         rsp_taken <= rsp_chan.valid && rsp_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            parse_byte(req_chan.rx_byte);
            bytes_accepted++;
         end
         if (rsp_chan.valid && rsp_chan.ready) check_result();
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // long receiver hold-offs so the result queue fills and the input stalls
   initial begin
      wait (bytes_accepted >= 500);
      hold_results = 1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_results = 0;
      wait (bytes_accepted >= 1300);
      hold_results = 1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_results = 0;
   end

   // ------------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      clear_sentence();

      // stray bytes before any sentence are ignored
      add_text("ok\r\n");
      sentence_stream = body_bytes;
      body_bytes.delete();
      add_sentence("CVW,1,2.5,-3.25,0.001,4.9999,7", CK_GOOD_UPPER);
      add_sentence("DPV,10,1.5,2.25,-0.75,3,5.7,6,7,-8", CK_GOOD_UPPER);
      add_sentence({"SWV,-2147483648,99999999999,-99999999999,2147483.647,",
                    "-2147483.648,2147483.648,123"}, CK_GOOD_UPPER);
      add_sentence("CMD,RUN", CK_GOOD_UPPER);
      add_sentence("CMD,CHK", CK_GOOD_LOWER);
      add_sentence("CMD,DIE", CK_GOOD_UPPER);
      add_sentence("CMD,TIA, 12x", CK_GOOD_UPPER);
      add_sentence("CMD,TIA,1.9", CK_GOOD_LOWER);
      add_sentence("CMD,CUR,\t-40", CK_GOOD_UPPER);
      add_sentence("XYZ,1,2", CK_GOOD_UPPER);
      add_sentence("SWV,,3,,+4,.5,-,abc,9", CK_GOOD_UPPER);
      add_sentence("CVW,1,2,", CK_GOOD_UPPER);
      add_sentence("CVW,0.12345,-0.0009", CK_GOOD_UPPER);
      add_sentence("CVW,1,2", CK_BAD_HIGH);
      add_sentence("DPV,3", CK_BAD_LOW);
      add_sentence("XYZ", CK_BAD_HIGH);
      add_sentence("CVW,5", CK_WRONG);
      // a new dollar abandons the sentence in flight
      add_sentence("CVW,12,3", CK_TRUNCATED);
      add_sentence("DPV,4,5", CK_STAR_ONLY);
      add_sentence("DPV,4,5", CK_GOOD_UPPER);

      while (sentence_stream.size() < TARGET_BYTES) add_random_sentence();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (sentence_stream.size() > 0 || req_chan.valid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_results.size() > 0) begin
         error_count += expected_results.size();
         $display("ERROR: %0d predicted items never arrived", expected_results.size());
      end
      $display("Run: %0d bytes in %0d sentences, %0d field items and %0d sentence ends",
               bytes_accepted, sentences_made, field_results, end_results);
      $display("Covered all commands, saturation, empty fields, bad checksums, stalls");
      $display("Errors: %0d", error_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/csp_pkg.sv
design/csp_if.sv
design/csp_front.sv
design/csp_queue.sv
design/csp_back.sv
design/command_sentence_parser.sv
dv/testbench.sv
